FILE: src/u8u16_pkg.sv
// ============================================================================
// u8u16_pkg: shared types and constants of the UTF-8 to UTF-16 stream block
// Holds the decoder state record, the result record and the fixed code values.
// ============================================================================
`default_nettype none

package u8u16_pkg;

  // Upper bound on the units of one string, applied on top of the capacity
  // register.
  localparam logic [8:0]  MaxUnits          = 9'd256;
  localparam logic [8:0]  CapacityReset     = 9'd256;

  localparam logic [15:0] ReplacementChar   = 16'h003F;
  localparam logic [15:0] HighSurrogateBase = 16'hD800;
  localparam logic [15:0] LowSurrogateBase  = 16'hDC00;
  localparam logic [20:0] SupplementaryBase = 21'h10000;

  typedef enum logic [1:0] {
    CauseNone     = 2'd0,
    CauseNul      = 2'd1,
    CauseCapacity = 2'd2
  } end_cause_e;

  typedef struct packed {
    logic [20:0] partial_code;
    logic [1:0]  pending;
    logic [8:0]  capacity_left;
    logic [8:0]  unit_count;
  } dec_state_t;

  typedef struct packed {
    logic [15:0] utf16_unit;
    logic        has_unit;
    logic        last;
    end_cause_e  end_cause;
    logic [8:0]  units_written;
  } result_t;

  // Outcome of one input byte: next state and up to two results, first first.
  typedef struct packed {
    dec_state_t state;
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } dec_step_t;

endpackage

`default_nettype wire

FILE: src/u8u16_byte_if.sv
// ============================================================================
// u8u16_byte_if: input byte channel
// Valid/ready channel that carries one raw UTF-8 byte per transfer.
// ============================================================================
`default_nettype none

interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

FILE: src/u8u16_unit_if.sv
// ============================================================================
// u8u16_unit_if: output result channel
// Valid/ready channel that carries one UTF-16 result per transfer.
// ============================================================================
`default_nettype none

interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] utf16_unit;
  logic        has_unit;
  logic        last;
  logic [1:0]  end_cause;
  logic [8:0]  units_written;

  modport source (output valid, output utf16_unit, output has_unit, output last,
                  output end_cause, output units_written, input ready);
  modport sink   (input valid, input utf16_unit, input has_unit, input last,
                  input end_cause, input units_written, output ready);
endinterface

`default_nettype wire

FILE: src/utf8_to_utf16_stream.sv
// ============================================================================
// utf8_to_utf16_stream: streaming UTF-8 to UTF-16 transcoder
// Decodes one UTF-8 byte per transfer into UTF-16 units with string framing.
// ============================================================================
// The block takes one UTF-8 byte per input transfer and one byte can be taken
// in every clock cycle while the output queue has room. Each byte is decoded
// in a single pass of shallow logic against the held decoder state, and its
// results (none, one or two) go into a three-entry output queue in the same
// cycle. A byte that yields two results (a surrogate pair, or a replacement
// character followed by the reprocessed byte) makes the output channel, at
// one result per cycle while the sink is ready, set the pace. Input is taken
// while the queue holds at most one result, so a finished result waiting on a
// stalled sink does not stop the next byte. A string ends on a NUL byte or
// when the output capacity runs out; that result carries last, the end cause
// and the number of units written, and the decoder then starts a new string
// with the capacity reloaded. Malformed bytes give '?'. The capacity register
// is written through cfg_we_i/cfg_data_i and is meant to be changed only while
// the block is idle; a write between strings loads the new capacity at once.
// ============================================================================
`default_nettype none

module utf8_to_utf16_stream (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [8:0]         cfg_data_i,
  u8u16_byte_if.sink         byte_i,
  u8u16_unit_if.source       unit_o
);

  // Output queue depth: two results per byte plus one waiting on the sink.
  localparam int QDepth = 3;
  localparam int CntW   = $clog2(QDepth + 1);

  u8u16_pkg::dec_state_t state_q, state_d;
  logic [8:0]            capacity_q, capacity_d;
  u8u16_pkg::dec_step_t  step;
  logic [8:0]            eff_capacity;
  logic [8:0]            eff_cfg;

  u8u16_pkg::result_t    queue_q [QDepth];
  u8u16_pkg::result_t    queue_d [QDepth];
  logic [CntW-1:0]       count_q, count_d;

  logic                  push;
  logic                  pop;

  // The effective capacity is clipped to the largest string the block allows.
  assign eff_capacity = (capacity_q > u8u16_pkg::MaxUnits) ? u8u16_pkg::MaxUnits
                                                           : capacity_q;
  assign eff_cfg      = (cfg_data_i > u8u16_pkg::MaxUnits) ? u8u16_pkg::MaxUnits
                                                           : cfg_data_i;

  u8u16_decode u_decode (
    .state_i        (state_q),
    .byte_i         (byte_i.in_byte),
    .eff_capacity_i (eff_capacity),
    .step_o         (step)
  );

  // Room for the two results a byte may produce, without looking at the sink.
  assign byte_i.ready = (count_q <= CntW'(QDepth - 2));
  assign push         = byte_i.valid && byte_i.ready;
  assign pop          = unit_o.valid && unit_o.ready;

  // Decoder state and capacity register. A capacity write reloads the count
  // of units left only when no string is in progress.
  always_comb begin
    state_d    = state_q;
    capacity_d = capacity_q;
    if (push) begin
      state_d = step.state;
    end
    if (cfg_we_i) begin
      capacity_d = cfg_data_i;
      if (state_q.unit_count == 9'd0 && state_q.pending == 2'd0) begin
        state_d.capacity_left = eff_cfg;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q              <= u8u16_pkg::CapacityReset;
      state_q.partial_code    <= '0;
      state_q.pending         <= '0;
      state_q.capacity_left   <= u8u16_pkg::CapacityReset;
      state_q.unit_count      <= '0;
      count_q                 <= '0;
    end else begin
      capacity_q <= capacity_d;
      state_q    <= state_d;
      count_q    <= count_d;
    end
  end

  // Shifting output queue: the head is always entry 0. On a pop everything
  // moves down one place, and new results land right behind what remains.
  always_comb begin
    logic [CntW-1:0] base;
    logic [1:0]      push_n;

    base   = count_q - CntW'(pop);
    push_n = push ? step.count : 2'd0;

    for (int i = 0; i < QDepth - 1; i++) begin
      queue_d[i] = pop ? queue_q[i + 1] : queue_q[i];
    end
    queue_d[QDepth - 1] = queue_q[QDepth - 1];

    for (int i = 0; i < QDepth; i++) begin
      if (push_n != 2'd0 && base == CntW'(i)) begin
        queue_d[i] = step.first;
      end
      if (push_n == 2'd2 && base + CntW'(1) == CntW'(i)) begin
        queue_d[i] = step.second;
      end
    end

    count_d = base + CntW'(push_n);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      queue_q[i] <= queue_d[i];
    end
  end

  assign unit_o.valid         = (count_q != '0);
  assign unit_o.utf16_unit    = queue_q[0].utf16_unit;
  assign unit_o.has_unit      = queue_q[0].has_unit;
  assign unit_o.last          = queue_q[0].last;
  assign unit_o.end_cause     = 2'(queue_q[0].end_cause);
  assign unit_o.units_written = queue_q[0].units_written;

endmodule

`default_nettype wire

FILE: src/u8u16_decode.sv
// ============================================================================
// u8u16_decode: per-byte transcoding step
// Combinational decode of one byte against the current state, including the
// reprocessing of a byte that broke a sequence.
// ============================================================================
`default_nettype none

module u8u16_decode (
  input  u8u16_pkg::dec_state_t state_i,
  input  logic [7:0]            byte_i,
  input  logic [8:0]            eff_capacity_i,
  output u8u16_pkg::dec_step_t  step_o
);

  typedef struct packed {
    logic        ok;
    logic [1:0]  pending;
    logic [20:0] partial;
  } lead_t;

  function automatic lead_t lead_decode(logic [7:0] b);
    lead_t r;
    r = '0;
    priority if (b[7] == 1'b0) begin
      r.ok      = 1'b1;
      r.partial = {13'd0, b};
    end else if (b[7:5] == 3'b110) begin
      r.ok      = (b[4:1] != 4'd0);
      r.pending = 2'd1;
      r.partial = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      r.ok      = 1'b1;
      r.pending = 2'd2;
      r.partial = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      r.ok      = 1'b1;
      r.pending = 2'd3;
      r.partial = {18'd0, b[2:0]};
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic u8u16_pkg::result_t unit_result(logic [15:0] u, logic ends,
                                                     logic [8:0] written);
    u8u16_pkg::result_t r;
    r.utf16_unit    = u;
    r.has_unit      = 1'b1;
    r.last          = ends;
    r.end_cause     = ends ? u8u16_pkg::CauseCapacity : u8u16_pkg::CauseNone;
    r.units_written = ends ? written : 9'd0;
    return r;
  endfunction

  function automatic u8u16_pkg::result_t marker(u8u16_pkg::end_cause_e cause,
                                                logic [8:0] written);
    u8u16_pkg::result_t r;
    r.utf16_unit    = 16'd0;
    r.has_unit      = 1'b0;
    r.last          = 1'b1;
    r.end_cause     = cause;
    r.units_written = written;
    return r;
  endfunction

  always_comb begin
    u8u16_pkg::dec_step_t  s;
    u8u16_pkg::dec_state_t rearm;
    lead_t                 ld;
    logic [20:0]           cont_code;
    logic [1:0]            cont_pend;
    logic                  ok0;
    logic                  again;
    logic [1:0]            pend0;
    logic [20:0]           code0;
    logic [20:0]           off;
    logic [1:0]            pend1;
    logic [20:0]           code1;
    logic [8:0]            cnt1;
    logic [8:0]            cap1;

    rearm.partial_code  = '0;
    rearm.pending       = '0;
    rearm.capacity_left = eff_capacity_i;
    rearm.unit_count    = '0;

    s.state  = state_i;
    s.count  = 2'd0;
    s.first  = '0;
    s.second = '0;

    ld        = lead_decode(byte_i);
    cont_code = {state_i.partial_code[14:0], byte_i[5:0]};
    cont_pend = state_i.pending - 2'd1;

    if (state_i.pending != 2'd0) begin
      // Continuation byte, with the overlong checks after the second byte.
      ok0   = (byte_i[7:6] == 2'b10) &&
              !((cont_pend == 2'd1 && cont_code <= 21'h1F) ||
                (cont_pend == 2'd2 && cont_code <= 21'h0F));
      pend0 = cont_pend;
      code0 = cont_code;
    end else begin
      ok0   = ld.ok;
      pend0 = ld.pending;
      code0 = ld.partial;
    end
    again = !ok0 && (state_i.pending != 2'd0);
    if (!ok0) begin
      pend0 = 2'd0;
      code0 = {5'd0, u8u16_pkg::ReplacementChar};
    end

    off   = code0 - u8u16_pkg::SupplementaryBase;
    cnt1  = state_i.unit_count + 9'd1;
    cap1  = state_i.capacity_left - 9'd1;
    pend1 = ld.ok ? ld.pending : 2'd0;
    code1 = ld.ok ? ld.partial : {5'd0, u8u16_pkg::ReplacementChar};

    priority if (state_i.capacity_left == 9'd0) begin
      s.count = 2'd1;
      s.first = marker(u8u16_pkg::CauseCapacity, state_i.unit_count);
      s.state = rearm;
    end else if (pend0 != 2'd0) begin
      s.state.partial_code = code0;
      s.state.pending      = pend0;
    end else if (code0 == 21'd0) begin
      s.count = 2'd1;
      s.first = marker(u8u16_pkg::CauseNul, state_i.unit_count);
      s.state = rearm;
    end else if (code0[20:16] != 5'd0) begin
      if (state_i.capacity_left < 9'd2) begin
        s.count = 2'd1;
        s.first = marker(u8u16_pkg::CauseCapacity, state_i.unit_count);
        s.state = rearm;
      end else begin
        s.count  = 2'd2;
        s.first  = unit_result(u8u16_pkg::HighSurrogateBase | {6'd0, off[19:10]},
                               1'b0, 9'd0);
        s.second = unit_result(u8u16_pkg::LowSurrogateBase | {6'd0, off[9:0]},
                               state_i.capacity_left == 9'd2,
                               state_i.unit_count + 9'd2);
        if (state_i.capacity_left == 9'd2) begin
          s.state = rearm;
        end else begin
          s.state.partial_code  = code0;
          s.state.pending       = 2'd0;
          s.state.unit_count    = state_i.unit_count + 9'd2;
          s.state.capacity_left = state_i.capacity_left - 9'd2;
        end
      end
    end else if (cap1 == 9'd0) begin
      // This unit takes the last slot; a byte waiting for reprocessing is dropped.
      s.count = 2'd1;
      s.first = unit_result(code0[15:0], 1'b1, cnt1);
      s.state = rearm;
    end else begin
      s.count               = 2'd1;
      s.first               = unit_result(code0[15:0], 1'b0, 9'd0);
      s.state.partial_code  = code0;
      s.state.pending       = 2'd0;
      s.state.unit_count    = cnt1;
      s.state.capacity_left = cap1;
      if (again) begin
        // The byte that broke the sequence starts over as a lead byte.
        priority if (pend1 != 2'd0) begin
          s.state.partial_code = code1;
          s.state.pending      = pend1;
        end else if (code1 == 21'd0) begin
          s.count  = 2'd2;
          s.second = marker(u8u16_pkg::CauseNul, cnt1);
          s.state  = rearm;
        end else begin
          s.count  = 2'd2;
          s.second = unit_result(code1[15:0], cap1 == 9'd1, cnt1 + 9'd1);
          if (cap1 == 9'd1) begin
            s.state = rearm;
          end else begin
            s.state.partial_code  = code1;
            s.state.unit_count    = cnt1 + 9'd1;
            s.state.capacity_left = cap1 - 9'd1;
          end
        end
      end
    end

    step_o = s;
  end

endmodule

`default_nettype wire
